// ===== src/c3f_pkg.sv =====
// Shared types, constants and kernel codes of the 3x3 convolution filter core.
// No dependencies; every other file of the block but c3f_ram imports this package.
package c3f_pkg;

	localparam int MAX_LINE    = 1024;
	localparam int MAX_HEIGHT  = 4096;
	localparam int MIN_SIZE    = 3;
	localparam int BORDER      = 2;
	localparam int COL_W       = $clog2(MAX_LINE);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);

	localparam int PIX_W       = 8;
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 13;
	localparam int MODE_W      = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 2;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

	// kernel arithmetic
	localparam int SUM_W       = 13;
	localparam int MAG_W       = 12;
	localparam int RECIP_W     = 22;
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam int BOX_SHIFT   = 25;
	localparam int BOX_RECIP   = 3727898;   // ceil(2^25 * 0.1111)
	localparam int DIV3_SHIFT  = 12;
	localparam int DIV3_RECIP  = 1366;      // ceil(2^12 / 3)
	localparam int GAUSS_SHIFT = 4;
	localparam int SOBEL_SHIFT = 2;
	localparam int LAP8_SHIFT  = 3;
	localparam int PIX_MAX     = 255;

	// output queue
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int OCC_W       = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_KERNEL_MODE  = 2'd2
	} cfg_index_t;

	typedef enum logic [MODE_W-1:0] {
		K_BOX       = 3'd0,
		K_GAUSS     = 3'd1,
		K_PREWITT_X = 3'd2,
		K_PREWITT_Y = 3'd3,
		K_SOBEL_X   = 3'd4,
		K_SOBEL_Y   = 3'd5,
		K_LAP8      = 3'd6,
		K_LAP9      = 3'd7
	} kernel_t;

	typedef logic [PIX_W-1:0] pix_t;

	// window[row][col]; row 0 is the oldest line, col 0 the oldest column
	typedef logic [2:0][2:0][PIX_W-1:0] window_t;

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
	} win_beat_t;

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
		pix_t pix;
	} res_beat_t;

	typedef struct packed {
		logic last;
		pix_t pix;
	} result_t;

endpackage

// ===== src/c3f_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module c3f_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/c3f_window.sv =====
// Position tracking, line store (both lines in one RAM word) and 3x3 window.
// Depends on c3f_pkg and c3f_ram.
module c3f_window
	import c3f_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  pix_t                pixel_in,
	input  logic                frame_start,
	input  logic [WIDTH_W-1:0]  image_width,
	input  logic [HEIGHT_W-1:0] image_height,
	output logic                clr_busy,
	output window_t             window,
	output win_beat_t           win_beat
);

	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	logic [COL_W-1:0] col_q, c_base, col_cur, col_nxt;
	logic [ROW_W-1:0] row_q, r_base, row_cur, row_nxt;
	logic [ROW_W:0]   r_inc, r_wrap;
	logic [COL_W:0]   c_inc;
	logic             emit_cur, last_cur;

	logic             v_s1, emit_s1, last_s1, fwd_s1;
	logic [COL_W-1:0] col_s1;
	pix_t             px_s1;
	logic [2*PIX_W-1:0] fwd_data_s1;

	logic             clr_busy_q;
	logic [COL_W-1:0] clr_addr_q;

	logic               ram_we;
	logic [COL_W-1:0]   ram_waddr;
	logic [2*PIX_W-1:0] ram_wdata, ram_rdata, line_old;
	pix_t               a_old, b_old;

	// clamp the frame size
	always_comb begin
		if (image_width < WIDTH_W'(MIN_SIZE)) begin
			w_eff = WIDTH_W'(MIN_SIZE);
		end else if (image_width > WIDTH_W'(MAX_LINE)) begin
			w_eff = WIDTH_W'(MAX_LINE);
		end else begin
			w_eff = image_width;
		end
		if (image_height < HEIGHT_W'(MIN_SIZE)) begin
			h_eff = HEIGHT_W'(MIN_SIZE);
		end else if (image_height > HEIGHT_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			h_eff = image_height;
		end
	end

	// position of the arriving pixel and of the one after it
	always_comb begin
		c_base = frame_start ? '0 : col_q;
		r_base = frame_start ? '0 : row_q;
		if (WIDTH_W'(c_base) >= w_eff) begin
			col_cur = '0;
			r_inc   = {1'b0, r_base} + 1'b1;
		end else begin
			col_cur = c_base;
			r_inc   = {1'b0, r_base};
		end
		row_cur = (HEIGHT_W'(r_inc) >= h_eff) ? '0 : r_inc[ROW_W-1:0];

		c_inc  = {1'b0, col_cur} + 1'b1;
		r_wrap = {1'b0, row_cur} + 1'b1;
		if (WIDTH_W'(c_inc) >= w_eff) begin
			col_nxt = '0;
			row_nxt = (HEIGHT_W'(r_wrap) >= h_eff) ? '0 : r_wrap[ROW_W-1:0];
		end else begin
			col_nxt = c_inc[COL_W-1:0];
			row_nxt = row_cur;
		end

		emit_cur = (row_cur >= ROW_W'(BORDER)) && (col_cur >= COL_W'(BORDER));
		last_cur = (HEIGHT_W'(row_cur) == h_eff - 1'b1)
			&& (WIDTH_W'(col_cur) == w_eff - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			v_s1       <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == COL_W'(MAX_LINE - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// the word written back at this edge may be the one just read: forward it
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= col_cur;
			px_s1   <= pixel_in;
			emit_s1 <= emit_cur;
			last_s1 <= last_cur;
		end
		fwd_s1      <= v_s1 && (col_s1 == col_cur);
		fwd_data_s1 <= ram_wdata;
	end

	assign line_old  = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign a_old     = line_old[PIX_W-1:0];
	assign b_old     = line_old[2*PIX_W-1:PIX_W];

	assign ram_we    = clr_busy_q | v_s1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : col_s1;
	assign ram_wdata = clr_busy_q ? '0 : {a_old, px_s1};

	c3f_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_LINE)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(col_cur),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window   <= '0;
			win_beat <= '0;
		end else begin
			win_beat.valid <= v_s1;
			win_beat.emit  <= v_s1 & emit_s1;
			win_beat.last  <= last_s1;
			if (v_s1) begin
				for (int r = 0; r < 3; r++) begin
					window[r][0] <= window[r][1];
					window[r][1] <= window[r][2];
				end
				window[0][2] <= b_old;
				window[1][2] <= a_old;
				window[2][2] <= px_s1;
			end
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

// ===== src/c3f_kernel.sv =====
// Kernel datapath: weighted sum, magnitude and reciprocal multiply, final scale.
// Depends on c3f_pkg.
module c3f_kernel
	import c3f_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  kernel_t   kernel_mode,
	input  window_t   window,
	input  win_beat_t win_beat,
	output res_beat_t res_beat
);

	logic signed [SUM_W-1:0] p [3][3];
	logic signed [SUM_W-1:0] total, ksum;

	win_beat_t               beat_s3, beat_s4;
	logic signed [SUM_W-1:0] sum_s3, sum_s4;
	logic [MAG_W-1:0]        mag, mag_s4;
	logic [RECIP_W-1:0]      recip;
	logic [PROD_W-1:0]       prod_s4;
	pix_t                    pix;

	always_comb begin
		total = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				p[r][c] = $signed({{(SUM_W - PIX_W){1'b0}}, window[r][c]});
				total   = total + p[r][c];
			end
		end
	end

	always_comb begin
		case (kernel_mode)
			K_BOX: ksum = total;
			K_GAUSS: ksum = p[0][0] + (p[0][1] <<< 1) + p[0][2]
				+ (p[1][0] <<< 1) + (p[1][1] <<< 2) + (p[1][2] <<< 1)
				+ p[2][0] + (p[2][1] <<< 1) + p[2][2];
			K_PREWITT_X: ksum = p[0][2] + p[1][2] + p[2][2]
				- p[0][0] - p[1][0] - p[2][0];
			K_PREWITT_Y: ksum = p[2][0] + p[2][1] + p[2][2]
				- p[0][0] - p[0][1] - p[0][2];
			K_SOBEL_X: ksum = p[0][2] + (p[1][2] <<< 1) + p[2][2]
				- p[0][0] - (p[1][0] <<< 1) - p[2][0];
			K_SOBEL_Y: ksum = p[2][0] + (p[2][1] <<< 1) + p[2][2]
				- p[0][0] - (p[0][1] <<< 1) - p[0][2];
			K_LAP8: ksum = (p[1][1] <<< 3) + p[1][1] - total;
			K_LAP9: ksum = (p[1][1] <<< 3) + (p[1][1] <<< 1) - total;
			default: ksum = total;
		endcase
	end

	always_comb begin
		mag   = (sum_s3 < 0) ? MAG_W'(-sum_s3) : MAG_W'(sum_s3);
		recip = (kernel_mode == K_BOX) ? RECIP_W'(BOX_RECIP) : RECIP_W'(DIV3_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s3 <= '0;
			beat_s4 <= '0;
		end else begin
			beat_s3 <= win_beat;
			beat_s4 <= beat_s3;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3  <= ksum;
		sum_s4  <= sum_s3;
		mag_s4  <= mag;
		prod_s4 <= PROD_W'(mag) * PROD_W'(recip);
	end

	always_comb begin
		case (kernel_mode)
			K_BOX:       pix = prod_s4[BOX_SHIFT +: PIX_W];
			K_GAUSS:     pix = mag_s4[GAUSS_SHIFT +: PIX_W];
			K_PREWITT_X: pix = prod_s4[DIV3_SHIFT +: PIX_W];
			K_PREWITT_Y: pix = prod_s4[DIV3_SHIFT +: PIX_W];
			K_SOBEL_X:   pix = mag_s4[SOBEL_SHIFT +: PIX_W];
			K_SOBEL_Y:   pix = mag_s4[SOBEL_SHIFT +: PIX_W];
			K_LAP8:      pix = mag_s4[LAP8_SHIFT +: PIX_W];
			K_LAP9: begin
				if (sum_s4 < 0) begin
					pix = '0;
				end else if (sum_s4 > SUM_W'(PIX_MAX)) begin
					pix = '1;
				end else begin
					pix = sum_s4[PIX_W-1:0];
				end
			end
			default:     pix = '0;
		endcase
	end

	always_comb begin
		res_beat.valid = beat_s4.valid;
		res_beat.emit  = beat_s4.emit;
		res_beat.last  = beat_s4.last;
		res_beat.pix   = pix;
	end

endmodule

// ===== src/c3f_out_fifo.sv =====
// Result queue between the kernel pipeline and the output channel.
// Depends on c3f_pkg.
module c3f_out_fifo
	import c3f_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    head_valid,
	output result_t head_data
);

	result_t            mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OCC_W'(push) - OCC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = (count_q != '0);
	assign head_data  = mem[rd_ptr_q];

endmodule

// ===== src/convolution_3x3_filter_core.sv =====
// 3x3 convolution filter core: box, gauss, prewitt, sobel and laplace kernels.
// Throughput: one pixel per cycle while in_stall is low, set by the single read and write port of the line RAM.
// A result is offered on out_valid once its pixel beat has passed s1, the window, s3, s4 and the queue.
// Reset: counters and window clear and config takes its reset values at once; the line
// RAM then runs a clearing pass over all 1024 words, one word a cycle, with in_stall held high.
// Depends on c3f_pkg, c3f_window, c3f_kernel and c3f_out_fifo.
module convolution_3x3_filter_core
	import c3f_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PIX_W-1:0]       pixel_in,
	input  logic                   frame_start,

	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PIX_W-1:0]       pixel_out,
	output logic                   frame_last
);

	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	kernel_t             kernel_mode_q;

	logic      accept, pop, push, drop;
	logic      clr_busy;
	logic [OCC_W-1:0] occ_q;

	window_t   window;
	win_beat_t win_beat;
	res_beat_t res_beat;
	result_t   push_data, head_data;

	// Configuration registers: the user must write them only while the pipeline is empty; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			kernel_mode_q  <= K_GAUSS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_KERNEL_MODE:  kernel_mode_q  <= kernel_t'(cfg_data[MODE_W-1:0]);
				default: ;
			endcase
		end
	end

	// Occupancy counts every beat in flight plus every queued result, so the
	// queue can never overflow however long the output side stalls. Drop a
	// border beat from the count when it leaves the last kernel stage.
	assign accept = in_valid & ~in_stall;
	assign pop    = out_valid & ~out_stall;
	assign push   = res_beat.valid & res_beat.emit;
	assign drop   = res_beat.valid & ~res_beat.emit;

	assign in_stall = clr_busy | (occ_q == OCC_W'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(accept) - OCC_W'(pop) - OCC_W'(drop);
		end
	end

	// Line RAM read at acceptance, window shifted in the following cycle.
	c3f_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel_in    (pixel_in),
		.frame_start (frame_start),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.clr_busy    (clr_busy),
		.window      (window),
		.win_beat    (win_beat)
	);

	// Sum, multiply, scale: kernel stages s3 and s4 behind the window, the scale combinational.
	c3f_kernel u_kernel (
		.clk        (clk),
		.arst_n     (arst_n),
		.kernel_mode(kernel_mode_q),
		.window     (window),
		.win_beat   (win_beat),
		.res_beat   (res_beat)
	);

	assign push_data.last = res_beat.last;
	assign push_data.pix  = res_beat.pix;

	// Output queue parts the pipeline from the output handshake.
	c3f_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_valid(out_valid),
		.head_data (head_data)
	);

	assign pixel_out  = head_data.pix;
	assign frame_last = head_data.last;

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(FIFO_DEPTH))
		else $error("occupancy beyond queue depth");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> (!out_valid && occ_q == '0))
		else $error("beat in flight during line RAM clearing");

	a_empty_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> !out_valid)
		else $error("result offered with nothing in flight");

	a_window_timing: assert property (@(posedge clk) disable iff (!arst_n)
		win_beat.valid |-> $past(accept, 2))
		else $error("window beat without matching input beat");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for convolution_3x3_filter_core: random-paced pixel beats
// against a line-store and window predictor. Depends on c3f_pkg and the RTL core.
module tb_top;
	import c3f_pkg::*;

	// Longest correct quiet stretch is the line RAM clear over all 1024 words; allow four times that.
	localparam int QUIET_LIMIT  = 4096;
	// Border pixels leave no result, so hold this long past the last result
	// before touching registers.
	localparam int PIPE_SETTLE  = 8;
	localparam int RANDOM_ITEMS = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_wr_en = 1'b0;
	cfg_index_t            cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic       in_valid = 1'b0;
	logic       in_stall;
	pix_t       pixel_in = '0;
	logic       frame_start = 1'b0;

	logic       out_valid;
	logic       out_stall = 1'b0;
	pix_t       pixel_out;
	logic       frame_last;

	// Pacing switch shared by both sides; cleared for full-rate stretches.
	bit idle_en = 1'b1;

	int unsigned pixels_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	// Shadow of the configuration registers.
	logic [WIDTH_W-1:0]  width_reg = WIDTH_RESET;
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
	kernel_t             mode_reg = K_GAUSS;

	// Shadow of the datapath: two line stores, the 3x3 window and the raster position.
	pix_t line_a [MAX_LINE];
	pix_t line_b [MAX_LINE];
	pix_t win [3][3];
	int   col_pos = 0;
	int   row_pos = 0;

	// Filtered pixels still owed by the core, oldest first.
	result_t filtered_q [$];

	convolution_3x3_filter_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_in    (pixel_in),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_out   (pixel_out),
		.frame_last  (frame_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	//------------------------------------------------------------------
	// Predictor
	//------------------------------------------------------------------

	function automatic int eff_width();
		int w;
		w = int'(width_reg);
		if (w < MIN_SIZE) w = MIN_SIZE;
		if (w > MAX_LINE) w = MAX_LINE;
		return w;
	endfunction

	function automatic int eff_height();
		int h;
		h = int'(height_reg);
		if (h < MIN_SIZE) h = MIN_SIZE;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return h;
	endfunction

	function automatic int magnitude(int s);
		return (s < 0) ? -s : s;
	endfunction

	// Apply the selected kernel to the current window.
	function automatic pix_t filter_window();
		int p [3][3];
		int sum;
		int v;
		sum = 0;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				p[r][c] = int'(win[r][c]);
				sum += p[r][c];
			end
		case (mode_reg)
			K_BOX: begin
				v = (sum * 1111) / 10000;
			end
			K_GAUSS: begin
				v = (p[0][0] + 2 * p[0][1] + p[0][2]
				   + 2 * p[1][0] + 4 * p[1][1] + 2 * p[1][2]
				   + p[2][0] + 2 * p[2][1] + p[2][2]) >> 4;
			end
			K_PREWITT_X: begin
				v = magnitude(p[0][2] + p[1][2] + p[2][2] - p[0][0] - p[1][0] - p[2][0]) / 3;
			end
			K_PREWITT_Y: begin
				v = magnitude(p[2][0] + p[2][1] + p[2][2] - p[0][0] - p[0][1] - p[0][2]) / 3;
			end
			K_SOBEL_X: begin
				v = magnitude(p[0][2] + 2 * p[1][2] + p[2][2]
				            - p[0][0] - 2 * p[1][0] - p[2][0]) / 4;
			end
			K_SOBEL_Y: begin
				v = magnitude(p[2][0] + 2 * p[2][1] + p[2][2]
				            - p[0][0] - 2 * p[0][1] - p[0][2]) / 4;
			end
			K_LAP8: begin
				v = magnitude(9 * p[1][1] - sum) / 8;
			end
			default: begin
				// laplace with centre 9: clamp instead of magnitude
				v = 10 * p[1][1] - sum;
				if (v < 0) v = 0;
				if (v > PIX_MAX) v = PIX_MAX;
			end
		endcase
		return pix_t'(v);
	endfunction

	// Advance the shadow datapath by one accepted pixel beat and queue its result, if any.
	function automatic void advance_window(pix_t px, logic fs);
		int w;
		int h;
		int col;
		int row;
		result_t res;
		w = eff_width();
		h = eff_height();
		// frame_start forces 0,0; a position left beyond a shrunken size wraps
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		col = col_pos;
		row = row_pos;

		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = line_b[col];
		win[1][2] = line_a[col];
		win[2][2] = px;
		line_b[col] = line_a[col];
		line_a[col] = px;

		// only interior centres produce a result
		if (row >= BORDER && col >= BORDER) begin
			res.pix  = filter_window();
			res.last = (row == h - 1 && col == w - 1);
			filtered_q.push_back(res);
		end

		col_pos = col + 1;
		row_pos = row;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) row_pos = 0;
		end
	endfunction

	//------------------------------------------------------------------
	// Stimulus helpers
	//------------------------------------------------------------------

	// Lean on the extremes a quarter of the time.
	function automatic pix_t rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one pixel beat after a random gap and hold it until the core takes it.
	task automatic push_pixel(pix_t px, logic fs);
		int unsigned gap;
		gap = idle_en ? $urandom_range(0, 5) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		pixel_in    <= px;
		frame_start <= fs;
		do @(posedge clk); while (in_stall !== 1'b0);
		advance_window(px, fs);
		pixels_sent++;
	endtask

	// Stream n random pixels; flag the first one as a frame start if asked.
	task automatic push_run(int unsigned n, logic fresh);
		for (int unsigned i = 0; i < n; i++)
			push_pixel(rand_pixel(), fresh && (i == 0));
	endtask

	// Drop valid, wait for every owed result, then let the pipeline empty.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	// One-cycle register write; mirror it in the shadow copy.
	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_IMAGE_WIDTH:  width_reg  = val[WIDTH_W-1:0];
			CFG_IMAGE_HEIGHT: height_reg = val[HEIGHT_W-1:0];
			CFG_KERNEL_MODE:  mode_reg   = kernel_t'(val[MODE_W-1:0]);
			default: ;
		endcase
	endtask

	//------------------------------------------------------------------
	// Tests
	//------------------------------------------------------------------

	// Reset sizes and gauss mode at full rate: the start of a first line, which owes no result.
	task automatic test_default_frame();
		idle_en = 1'b0;
		push_run(48, 1'b1);
	endtask

	// Width 3, so each line from the third completes one window; switch kernel before each of those lines.
	task automatic test_kernel_modes();
		pix_t pat [0:9][0:2];
		pat = '{'{8'd0,   8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
		        '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
		        '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd0,   8'd0},
		        '{8'd255, 8'd255, 8'd255}, '{8'd0,   8'd0,   8'd0},
		        '{8'd0,   8'd255, 8'd0},   '{8'd0,   8'd0,   8'd0}};
		idle_en = 1'b1;
		settle();
		write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(MIN_SIZE));
		write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_HEIGHT));
		for (int row = 0; row < 10; row++) begin
			if (row >= BORDER) begin
				settle();
				write_reg(CFG_KERNEL_MODE, CFG_DATA_W'(row - BORDER));
			end
			for (int c = 0; c < 3; c++)
				push_pixel(pat[row][c], (row == 0) && (c == 0));
		end
	endtask

	// Sizes below 3 are clamped; also wrap frames with no frame_start.
	task automatic test_size_clamp();
		settle();
		idle_en = 1'b1;
		write_reg(CFG_IMAGE_WIDTH, '0);
		write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(1));
		write_reg(CFG_KERNEL_MODE, CFG_DATA_W'(K_BOX));
		// two 3x3 frames of full white; the second one follows by wrap alone
		for (int i = 0; i < 18; i++)
			push_pixel('1, i == 0);
	endtask

	// Shrink width, then height, while the frame position is left past the new size.
	task automatic test_resize_mid_frame();
		settle();
		idle_en = 1'b1;
		write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(8));
		write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(6));
		write_reg(CFG_KERNEL_MODE, CFG_DATA_W'(K_SOBEL_X));
		push_run(20, 1'b1);
		settle();
		write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(MIN_SIZE));
		push_run(7, 1'b0);
		settle();
		write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(4));
		push_run(12, 1'b0);
	endtask

	// Mostly whole frames with random content; the rest continuations, cut frames and noise.
	task automatic test_random_frames();
		int unsigned start_count;
		int unsigned kind;
		int unsigned n;
		int unsigned w_val;
		int unsigned h_val;
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_ITEMS) begin
			settle();
			idle_en = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_KERNEL_MODE, CFG_DATA_W'($urandom_range(0, 7)));
			if ($urandom_range(0, 2) != 0) begin
				w_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(3, 12);
				write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
			end
			if ($urandom_range(0, 2) != 0) begin
				h_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
				write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
			end
			n = eff_width() * eff_height();
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				// one or two frames; the second follows by wrap
				push_run(n * $urandom_range(1, 2), 1'b1);
			end else if (kind == 7) begin
				push_run(n, 1'b0);
			end else if (kind == 8) begin
				// cut short: the next frame start lands early
				push_run($urandom_range(1, n - 1), 1'b1);
			end else begin
				repeat ($urandom_range(1, n))
					push_pixel(rand_pixel(), $urandom_range(0, 7) == 0);
			end
		end
	endtask

	//------------------------------------------------------------------
	// Result side
	//------------------------------------------------------------------

	// Draw a stall stretch before each result beat, then take the beat.
	initial begin : sink_pacing
		int unsigned hold;
		forever begin
			hold = idle_en ? $urandom_range(0, 5) : 0;
			@(negedge clk);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Compare each accepted result beat with the oldest owed one.
	always @(posedge clk) begin : check_results
		result_t head;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (filtered_q.size() == 0) begin
				$error("unexpected result beat: pixel_out %0d frame_last %0b",
				       pixel_out, frame_last);
				mismatch_count++;
			end else begin
				head = filtered_q.pop_front();
				if (pixel_out !== head.pix) begin
					$error("pixel_out: expected %0d, actual %0d", head.pix, pixel_out);
					mismatch_count++;
				end
				if (frame_last !== head.last) begin
					$error("frame_last: expected %0b, actual %0b", head.last, frame_last);
					mismatch_count++;
				end
			end
		end
	end

	// Abort if neither channel nor the register port moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("convolution_3x3_filter_core test failed");
			$finish;
		end
	end

	//------------------------------------------------------------------
	// Sequence
	//------------------------------------------------------------------

	initial begin
		line_a = '{default: '0};
		line_b = '{default: '0};
		win    = '{default: '0};

		// hold reset, then wait out the line RAM clearing pass
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);

		test_default_frame();
		test_kernel_modes();
		test_size_clamp();
		test_resize_mid_frame();
		test_random_frames();
		settle();

		$display("Sent %0d pixel beats and checked %0d filtered results over all eight kernels,",
		         pixels_sent, results_seen);
		$display("clamped sizes, frame wrap, early frame starts and resizes.");
		if (mismatch_count == 0 && filtered_q.size() == 0)
			$display("convolution_3x3_filter_core test passed");
		else
			$display("convolution_3x3_filter_core test failed");
		$finish;
	end

endmodule
